// ===== rtl/chbf_pkg.sv =====
package chbf_pkg;

  localparam int unsigned WORDS      = 16;
  localparam int unsigned ROUNDS     = 20;
  localparam int unsigned BEATS      = 8;
  localparam int unsigned ADDR_WIDTH = 6;
  localparam int unsigned DATA_WIDTH = 64;

  typedef logic [31:0] word_t;
  typedef logic [3:0]  widx_t;
  typedef logic [4:0]  round_t;
  typedef logic [2:0]  beat_t;
  typedef logic [2:0]  reg_idx_t;

  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  localparam round_t LAST_ROUND = round_t'(ROUNDS - 1);
  localparam beat_t  LAST_BEAT  = beat_t'(BEATS - 1);

  localparam reg_idx_t REG_KEY_0 = 3'd0;
  localparam reg_idx_t REG_KEY_1 = 3'd1;
  localparam reg_idx_t REG_KEY_2 = 3'd2;
  localparam reg_idx_t REG_KEY_3 = 3'd3;
  localparam reg_idx_t REG_NONCE = 3'd4;

  // word indices a, b, c, d of each quarter round; column round first, then diagonal
  localparam widx_t QR_IDX [2][4][4] = '{
    '{'{4'd0, 4'd4, 4'd8,  4'd12}, '{4'd1, 4'd5, 4'd9,  4'd13},
      '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15}},
    '{'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
      '{4'd2, 4'd7, 4'd8,  4'd13}, '{4'd3, 4'd4, 4'd9,  4'd14}}
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic  load;
    logic  step;
    logic  diag;
    logic  emit;
    beat_t beat;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce;
  } cfg_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter_round(input word_t a_in, input word_t b_in,
                                                 input word_t c_in, input word_t d_in);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    a = a_in;
    b = b_in;
    c = c_in;
    d = d_in;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    quarter_round = {a, b, c, d};
  endfunction

endpackage

// ===== rtl/chacha20_block_function.sv =====
// ChaCha20 block function, original variant with a 64-bit block counter and a 64-bit nonce.
// Load the key (four 64-bit little-endian parts at byte addresses 0x00..0x18) and the nonce
// (0x20) over the APB port while the block is idle, then send one block counter per item.
// Each item yields the 64-byte keystream block as eight 64-bit words, state words 2k and
// 2k+1 in the low and high halves, with word_index = k and last_word set on the eighth.
// One column or diagonal round of four quarter rounds runs per cycle, so an item is loaded,
// runs its 20 rounds, then emits its eight words, each only once the output register is free.
// The next counter is taken once the last word has entered the output register, even while
// that word is still waiting to be taken.
module chacha20_block_function (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] block_counter,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] keystream_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import chbf_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  chbf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  chbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  chbf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .block_counter  (block_counter),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keystream_word (keystream_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

endmodule

// ===== rtl/chbf_cfg.sv =====
module chbf_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [chbf_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [chbf_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [chbf_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                 pready,
  output chbf_pkg::cfg_t                       cfg
);
  import chbf_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_KEY_0: cfg.key[0] <= pwdata;
        REG_KEY_1: cfg.key[1] <= pwdata;
        REG_KEY_2: cfg.key[2] <= pwdata;
        REG_KEY_3: cfg.key[3] <= pwdata;
        REG_NONCE: cfg.nonce  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_0: prdata = cfg.key[0];
      REG_KEY_1: prdata = cfg.key[1];
      REG_KEY_2: prdata = cfg.key[2];
      REG_KEY_3: prdata = cfg.key[3];
      REG_NONCE: prdata = cfg.nonce;
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/chbf_ctrl.sv =====
module chbf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  chbf_pkg::dp_status_t  status,
  output chbf_pkg::dp_cmd_t     cmd
);
  import chbf_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  round_t      rnd;
  round_t      rnd_next;
  beat_t       beat;
  beat_t       beat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
      beat  <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
      beat  <= beat_next;
    end
  end

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    beat_next  = beat;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.diag   = rnd[0];
    cmd.beat   = beat;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          rnd_next   = '0;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.step = 1'b1;
        if (rnd == LAST_ROUND) begin
          beat_next  = '0;
          state_next = ST_OUT;
        end else begin
          rnd_next = rnd + 5'd1;
        end
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          beat_next = beat + 3'd1;
          if (beat == LAST_BEAT) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/chbf_dp.sv =====
module chbf_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  chbf_pkg::cfg_t        cfg,
  input  chbf_pkg::dp_cmd_t     cmd,
  output chbf_pkg::dp_status_t  status,
  input  logic [63:0]           block_counter,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           keystream_word,
  output logic [2:0]            word_index,
  output logic                  last_word
);
  import chbf_pkg::*;

  word_t       work      [WORDS];
  word_t       work_next [WORDS];
  word_t       init      [WORDS];
  logic [63:0] ctr;
  widx_t       lo_idx;
  widx_t       hi_idx;
  word_t       lo_sum;
  word_t       hi_sum;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init[i]         = SIGMA[i];
      init[4 + 2*i]   = cfg.key[i][31:0];
      init[5 + 2*i]   = cfg.key[i][63:32];
    end
    init[12] = ctr[31:0];
    init[13] = ctr[63:32];
    init[14] = cfg.nonce[31:0];
    init[15] = cfg.nonce[63:32];
  end

  always_comb begin
    logic [127:0] qr;
    for (int i = 0; i < WORDS; i++) begin
      work_next[i] = work[i];
    end
    for (int q = 0; q < 4; q++) begin
      qr = quarter_round(work[QR_IDX[cmd.diag][q][0]], work[QR_IDX[cmd.diag][q][1]],
                         work[QR_IDX[cmd.diag][q][2]], work[QR_IDX[cmd.diag][q][3]]);
      work_next[QR_IDX[cmd.diag][q][0]] = qr[127:96];
      work_next[QR_IDX[cmd.diag][q][1]] = qr[95:64];
      work_next[QR_IDX[cmd.diag][q][2]] = qr[63:32];
      work_next[QR_IDX[cmd.diag][q][3]] = qr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ctr <= block_counter;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WORDS; i++) begin
      if (cmd.load) begin
        unique case (i)
          12:           work[i] <= block_counter[31:0];
          13:           work[i] <= block_counter[63:32];
          14:           work[i] <= cfg.nonce[31:0];
          15:           work[i] <= cfg.nonce[63:32];
          default:      work[i] <= init[i];
        endcase
      end else if (cmd.step) begin
        work[i] <= work_next[i];
      end
    end
  end

  assign lo_idx = {cmd.beat, 1'b0};
  assign hi_idx = {cmd.beat, 1'b1};
  assign lo_sum = work[lo_idx] + init[lo_idx];
  assign hi_sum = work[hi_idx] + init[hi_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      keystream_word <= {hi_sum, lo_sum};
      word_index     <= cmd.beat;
      last_word      <= (cmd.beat == LAST_BEAT);
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== dv/chacha20_keystream_checker.sv =====
module chacha20_keystream_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic            pready,
  input  logic [5:0]      paddr,
  input  logic [63:0]     pwdata,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [63:0]     block_counter,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [63:0]     keystream_word,
  input  chbf_pkg::beat_t word_index,
  input  logic            last_word,
  output int              fail_count,
  output int              pending,
  output int              words_checked
);
  import chbf_pkg::*;

  localparam logic [127:0] PHRASE = "expand 32-byte k";
  localparam int DOUBLE_ROUNDS = 10;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [63:0] word;
    beat_t       index;
    logic        last;
  } ks_word_t;

  logic [3:0][63:0] key = '0;
  logic [63:0]      nonce = '0;
  ks_word_t         expected_words [$];
  ks_word_t         want;
  logic [7:0][63:0] blk;
  int               mismatches = 0;
  int               seen = 0;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [7:0][63:0] keystream_block(input logic [63:0] ctr);
    logic [31:0]      init [16];
    logic [31:0]      x [16];
    logic [7:0][63:0] res;
    int               a;
    int               b;
    int               c;
    int               d;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        init[i][8*j +: 8] = PHRASE[127 - 8*(4*i + j) -: 8];
      end
      init[4 + 2*i] = key[i][31:0];
      init[5 + 2*i] = key[i][63:32];
    end
    init[12] = ctr[31:0];
    init[13] = ctr[63:32];
    init[14] = nonce[31:0];
    init[15] = nonce[63:32];
    x = init;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      for (int q = 0; q < 8; q++) begin
        a = q % 4;
        b = 4 + ((q < 4) ? a : (a + 1) % 4);
        c = 8 + ((q < 4) ? a : (a + 2) % 4);
        d = 12 + ((q < 4) ? a : (a + 3) % 4);
        x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 7);
      end
    end
    for (int k = 0; k < 8; k++) begin
      res[k] = {x[2*k + 1] + init[2*k + 1], x[2*k] + init[2*k]};
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key = '0;
      nonce = '0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[5:3]))
          REG_KEY_0: key[0] = pwdata;
          REG_KEY_1: key[1] = pwdata;
          REG_KEY_2: key[2] = pwdata;
          REG_KEY_3: key[3] = pwdata;
          REG_NONCE: nonce = pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        blk = keystream_block(block_counter);
        for (int k = 0; k < BEATS; k++) begin
          expected_words.push_back('{word: blk[k], index: beat_t'(k),
                                     last: (k == BEATS - 1)});
        end
      end
      if (out_valid && out_ready) begin
        seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected keystream item: word %h index %0d last %0b",
                     keystream_word, word_index, last_word);
          end
        end else begin
          want = expected_words.pop_front();
          if (want.word !== keystream_word || want.index !== word_index ||
              want.last !== last_word) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("keystream mismatch: expected word %h index %0d last %0b,",
                       want.word, want.index, want.last,
                       " got word %h index %0d last %0b",
                       keystream_word, word_index, last_word);
            end
          end
        end
      end
    end
    pending <= expected_words.size();
    fail_count <= mismatches;
    words_checked <= seen;
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import chbf_pkg::*;

  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int IDLE_PCT = 21;
  localparam int SETTLE_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] block_counter;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] keystream_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        calm;

  int fail_count;
  int pending;
  int words_checked;
  int items_sent = 0;
  int settings = 1;

  logic [63:0] corner_counters [8] = '{
    64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
    64'h0000_0000_0000_0001, 64'h0000_0000_ffff_ffff,
    64'h0000_0001_0000_0000, 64'h8000_0000_0000_0000,
    64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  chacha20_block_function dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .block_counter  (block_counter),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keystream_word (keystream_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  chacha20_keystream_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .block_counter  (block_counter),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keystream_word (keystream_word),
    .word_index     (word_index),
    .last_word      (last_word),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_checked  (words_checked)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_counter(input logic [63:0] ctr);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    block_counter <= ctr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender until every keystream item has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] random_counter();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(15));
      3: return {$urandom, 32'hffff_ffff};
      4: return {32'h0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_settings();
    for (int i = REG_KEY_0; i <= REG_NONCE; i++) begin
      apb_write(reg_idx_t'(i), random_word());
    end
    if ($urandom_range(1) == 1) begin
      apb_write(reg_idx_t'($urandom_range(2 ** $bits(reg_idx_t) - 1, REG_NONCE + 1)),
                random_word());
    end
    settings++;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    block_counter <= '0;
    calm <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_counters[i]) send_counter(corner_counters[i]);

    wait_drained();
    for (int i = REG_KEY_0; i <= REG_NONCE; i++) apb_write(reg_idx_t'(i), '1);
    settings++;
    send_counter('0);
    send_counter('1);
    send_counter(64'h7fff_ffff_ffff_ffff);

    wait_drained();
    apb_write(REG_KEY_0, 64'h0706_0504_0302_0100);
    apb_write(REG_KEY_1, 64'h0f0e_0d0c_0b0a_0908);
    apb_write(REG_KEY_2, 64'h1716_1514_1312_1110);
    apb_write(REG_KEY_3, 64'h1f1e_1d1c_1b1a_1918);
    apb_write(REG_NONCE, 64'h4a00_0000_0900_0000);
    for (int i = REG_NONCE + 1; i < 2 ** $bits(reg_idx_t); i++) begin
      apb_write(reg_idx_t'(i), '1);
    end
    settings++;
    send_counter(64'h0000_0000_0000_0001);
    send_counter('0);
    send_counter('1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      random_settings();
      calm <= (p == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(39) == 0) wait_drained();
        send_counter(random_counter());
      end
    end

    wait_drained();
    calm <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d block counters under %0d key and nonce settings;",
             items_sent, settings, " %0d keystream items checked.", words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/chbf_pkg.sv
rtl/chbf_cfg.sv
rtl/chbf_ctrl.sv
rtl/chbf_dp.sv
rtl/chacha20_block_function.sv
dv/chacha20_keystream_checker.sv
dv/testbench.sv
